// ----- rtl/iet_pkg.sv -----
package iet_pkg;

  localparam int COORD_WIDTH = 12;

  localparam logic [COORD_WIDTH-1:0] RESET_MAX_X = COORD_WIDTH'(639);
  localparam logic [COORD_WIDTH-1:0] RESET_MAX_Y = COORD_WIDTH'(479);

  localparam logic FUNC_POP = 1'b1;

  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  localparam logic [15:0] AXIS_X = 16'd0;
  localparam logic [15:0] AXIS_Y = 16'd1;

  localparam logic [15:0] BUTTON_BASE = 16'h0110;
  localparam logic [15:0] BUTTON_LAST = 16'h0112;

  localparam logic [31:0] TABLET_FULL = 32'd32767;

  // depth of the decoded-word queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    REG_SCREEN_MAX_X = 1'b0,
    REG_SCREEN_MAX_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_POP,
    OP_BUTTON,
    OP_MODIFIER,
    OP_KEY,
    OP_REL_X,
    OP_REL_Y,
    OP_ABS_X,
    OP_ABS_Y
  } op_t;

  typedef struct packed {
    logic               func;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } event_t;

  typedef struct packed {
    logic [11:0] pointer_x;
    logic [11:0] pointer_y;
    logic [2:0]  button_bits;
    logic [3:0]  modifier_bits;
    logic        key_valid;
    logic [6:0]  key_code;
    logic [3:0]  key_modifiers;
    logic        key_pressed;
    logic        key_pending;
  } result_t;

  // decoded word handed from front to back
  typedef struct packed {
    op_t                    op;
    logic                   pressed;
    logic [3:0]             mask;
    logic [6:0]             keycode;
    logic signed [31:0]     delta;
    logic [COORD_WIDTH-1:0] coord;
  } work_t;

  typedef struct packed {
    logic       pressed;
    logic [3:0] mods;
    logic [6:0] code;
  } key_entry_t;

  // bit 7 marks a mapped code, low 7 bits hold the target keycode
  function automatic logic [7:0] key_lookup(input logic [6:0] code);
    logic [7:0] res;
    unique case (code)
      7'd1:   res = {1'b1, 7'h35};
      7'd2:   res = {1'b1, 7'h12};
      7'd3:   res = {1'b1, 7'h13};
      7'd4:   res = {1'b1, 7'h14};
      7'd5:   res = {1'b1, 7'h15};
      7'd6:   res = {1'b1, 7'h17};
      7'd7:   res = {1'b1, 7'h16};
      7'd8:   res = {1'b1, 7'h1A};
      7'd9:   res = {1'b1, 7'h1C};
      7'd10:  res = {1'b1, 7'h19};
      7'd11:  res = {1'b1, 7'h1D};
      7'd12:  res = {1'b1, 7'h1B};
      7'd13:  res = {1'b1, 7'h18};
      7'd14:  res = {1'b1, 7'h33};
      7'd15:  res = {1'b1, 7'h30};
      7'd16:  res = {1'b1, 7'h0C};
      7'd17:  res = {1'b1, 7'h0D};
      7'd18:  res = {1'b1, 7'h0E};
      7'd19:  res = {1'b1, 7'h0F};
      7'd20:  res = {1'b1, 7'h11};
      7'd21:  res = {1'b1, 7'h10};
      7'd22:  res = {1'b1, 7'h20};
      7'd23:  res = {1'b1, 7'h22};
      7'd24:  res = {1'b1, 7'h1F};
      7'd25:  res = {1'b1, 7'h23};
      7'd26:  res = {1'b1, 7'h21};
      7'd27:  res = {1'b1, 7'h1E};
      7'd28:  res = {1'b1, 7'h24};
      7'd30:  res = {1'b1, 7'h00};
      7'd31:  res = {1'b1, 7'h01};
      7'd32:  res = {1'b1, 7'h02};
      7'd33:  res = {1'b1, 7'h03};
      7'd34:  res = {1'b1, 7'h05};
      7'd35:  res = {1'b1, 7'h04};
      7'd36:  res = {1'b1, 7'h26};
      7'd37:  res = {1'b1, 7'h28};
      7'd38:  res = {1'b1, 7'h25};
      7'd39:  res = {1'b1, 7'h29};
      7'd40:  res = {1'b1, 7'h27};
      7'd41:  res = {1'b1, 7'h32};
      7'd43:  res = {1'b1, 7'h2A};
      7'd44:  res = {1'b1, 7'h06};
      7'd45:  res = {1'b1, 7'h07};
      7'd46:  res = {1'b1, 7'h08};
      7'd47:  res = {1'b1, 7'h09};
      7'd48:  res = {1'b1, 7'h0B};
      7'd49:  res = {1'b1, 7'h2D};
      7'd50:  res = {1'b1, 7'h2E};
      7'd51:  res = {1'b1, 7'h2B};
      7'd52:  res = {1'b1, 7'h2F};
      7'd53:  res = {1'b1, 7'h2C};
      7'd57:  res = {1'b1, 7'h31};
      7'd103: res = {1'b1, 7'h7E};
      7'd105: res = {1'b1, 7'h7B};
      7'd106: res = {1'b1, 7'h7C};
      7'd108: res = {1'b1, 7'h7D};
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] modifier_mask(input logic [15:0] code);
    logic [3:0] res;
    unique case (code)
      16'd42, 16'd54:   res = 4'b0001;
      16'd29, 16'd97:   res = 4'b0010;
      16'd56, 16'd100:  res = 4'b0100;
      16'd125, 16'd126: res = 4'b1000;
      default:          res = 4'b0000;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/iet_front.sv -----
module iet_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  iet_pkg::event_t                in_data,
  input  logic [iet_pkg::COORD_WIDTH-1:0] screen_max_x,
  input  logic [iet_pkg::COORD_WIDTH-1:0] screen_max_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output iet_pkg::work_t                 out_data
);
  import iet_pkg::*;

  localparam logic [16:0] REM_ONE = 17'(TABLET_FULL);
  localparam logic [16:0] REM_TWO = 17'(2 * TABLET_FULL);

  logic                   advance;
  work_t                  dec;
  logic [7:0]             lookup;
  logic [3:0]             mod_mask;
  logic [COORD_WIDTH-1:0] max_sel;
  logic [31:0]            prod;

  logic                   s1_valid;
  work_t                  s1_work;
  logic [31:0]            s1_prod;
  logic [COORD_WIDTH-1:0] s1_max;

  logic                   s2_valid;
  work_t                  s2_work;
  logic [17:0]            s2_qest;
  logic [16:0]            s2_rem;
  logic [COORD_WIDTH-1:0] s2_max;
  work_t                  s2_done;

  logic                   s3_valid;
  work_t                  s3_work;

  logic [32:0]            est_sum;
  logic [17:0]            qest;
  logic [32:0]            rem_full;
  logic [17:0]            quot;
  logic [COORD_WIDTH-1:0] scaled;

  // whole front moves together; it stalls only when its last stage is blocked
  assign advance  = !s3_valid || out_ready;
  assign in_ready = advance;

  assign lookup   = key_lookup(in_data.event_code[6:0]);
  assign mod_mask = modifier_mask(in_data.event_code);
  assign max_sel  = (in_data.event_code == AXIS_Y) ? screen_max_y : screen_max_x;
  // wrapping 32-bit product, as the tablet scale requires
  assign prod     = in_data.event_value * 32'(max_sel);

  always_comb begin
    dec         = '0;
    dec.op      = OP_NONE;
    dec.pressed = (in_data.event_value != 32'sd0);
    dec.delta   = in_data.event_value;
    dec.keycode = lookup[6:0];
    if (in_data.func == FUNC_POP) begin
      dec.op = OP_POP;
    end else if (in_data.event_type == EV_KEY) begin
      if (in_data.event_code >= BUTTON_BASE && in_data.event_code <= BUTTON_LAST) begin
        dec.op   = OP_BUTTON;
        dec.mask = 4'b0001 << in_data.event_code[1:0];
      end else if (mod_mask != 4'b0000) begin
        dec.op   = OP_MODIFIER;
        dec.mask = mod_mask;
      end else if (in_data.event_code[15:7] == 9'd0 && lookup[7]) begin
        dec.op = OP_KEY;
      end
    end else if (in_data.event_type == EV_REL) begin
      if (in_data.event_code == AXIS_X) begin
        dec.op = OP_REL_X;
      end else if (in_data.event_code == AXIS_Y) begin
        dec.op = OP_REL_Y;
      end
    end else if (in_data.event_type == EV_ABS) begin
      if (in_data.event_code == AXIS_X) begin
        dec.op = OP_ABS_X;
      end else if (in_data.event_code == AXIS_Y) begin
        dec.op = OP_ABS_Y;
      end
    end
  end

  // divide by 2^15-1: estimate p*(1+2^-15+2^-30)/2^15, never above the true quotient
  assign est_sum  = {1'b0, s1_prod} + 33'(s1_prod >> 15) + 33'(s1_prod >> 30);
  assign qest     = est_sum[32:15];
  assign rem_full = {1'b0, s1_prod} - {qest, 15'b0} + 33'(qest);

  // correct the estimate, then clamp to the screen max
  assign quot   = s2_qest + 18'(s2_rem >= REM_ONE) + 18'(s2_rem >= REM_TWO);
  assign scaled = (quot > 18'(s2_max)) ? s2_max : quot[COORD_WIDTH-1:0];

  always_comb begin
    s2_done = s2_work;
    if (s2_work.op == OP_ABS_X || s2_work.op == OP_ABS_Y) begin
      s2_done.coord = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_work <= dec;
      s1_prod <= prod;
      s1_max  <= max_sel;
      s2_work <= s1_work;
      s2_qest <= qest;
      s2_rem  <= rem_full[16:0];
      s2_max  <= s1_max;
      s3_work <= s2_done;
    end
  end

  assign out_valid = s3_valid;
  assign out_data  = s3_work;

endmodule

// ----- rtl/iet_queue.sv -----
module iet_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  iet_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output iet_pkg::work_t out_data
);
  import iet_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  work_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (PW + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/iet_back.sv -----
module iet_back #(
  parameter int KEY_FIFO_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  iet_pkg::work_t                  in_data,
  input  logic [iet_pkg::COORD_WIDTH-1:0] screen_max_x,
  input  logic [iet_pkg::COORD_WIDTH-1:0] screen_max_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output iet_pkg::result_t                out_data
);
  import iet_pkg::*;

  localparam int            PW   = $clog2(KEY_FIFO_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(KEY_FIFO_DEPTH - 1);
  localparam int            SW   = 34;

  logic [COORD_WIDTH-1:0] pointer_x;
  logic [COORD_WIDTH-1:0] pointer_x_next;
  logic [COORD_WIDTH-1:0] pointer_y;
  logic [COORD_WIDTH-1:0] pointer_y_next;
  logic [2:0]             buttons;
  logic [2:0]             buttons_next;
  logic [3:0]             modifiers;
  logic [3:0]             modifiers_next;
  logic [PW-1:0]          wr_ptr;
  logic [PW-1:0]          wr_ptr_next;
  logic [PW-1:0]          rd_ptr;
  logic [PW-1:0]          rd_ptr_next;

  key_entry_t             key_store [KEY_FIFO_DEPTH];
  key_entry_t             head;
  key_entry_t             entry;

  logic                   take;
  logic                   push;
  logic                   empty;
  logic                   full;
  logic [PW-1:0]          wr_step;
  logic [PW-1:0]          rd_step;
  logic [COORD_WIDTH-1:0] pos_sel;
  logic [COORD_WIDTH-1:0] max_sel;
  logic signed [SW-1:0]   rel_sum;
  logic [COORD_WIDTH-1:0] rel_pos;
  result_t                res;
  result_t                result;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign wr_step = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_step = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_step == rd_ptr);

  assign entry.pressed = in_data.pressed;
  assign entry.mods    = modifiers;
  assign entry.code    = in_data.keycode;

  // relative move: exact signed sum, clamped to 0..max
  assign pos_sel = (in_data.op == OP_REL_Y) ? pointer_y : pointer_x;
  assign max_sel = (in_data.op == OP_REL_Y) ? screen_max_y : screen_max_x;
  assign rel_sum = $signed({{(SW - COORD_WIDTH){1'b0}}, pos_sel}) + SW'(in_data.delta);

  always_comb begin
    if (rel_sum < 0) begin
      rel_pos = '0;
    end else if (rel_sum > $signed({{(SW - COORD_WIDTH){1'b0}}, max_sel})) begin
      rel_pos = max_sel;
    end else begin
      rel_pos = rel_sum[COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    pointer_x_next = pointer_x;
    pointer_y_next = pointer_y;
    buttons_next   = buttons;
    modifiers_next = modifiers;
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    push           = 1'b0;
    res            = '0;
    if (take) begin
      unique case (in_data.op)
        OP_POP: begin
          if (!empty) begin
            res.key_valid     = 1'b1;
            res.key_code      = head.code;
            res.key_modifiers = head.mods;
            res.key_pressed   = head.pressed;
            rd_ptr_next       = rd_step;
          end
        end
        OP_BUTTON: begin
          buttons_next = in_data.pressed ? (buttons | in_data.mask[2:0])
                                         : (buttons & ~in_data.mask[2:0]);
        end
        OP_MODIFIER: begin
          modifiers_next = in_data.pressed ? (modifiers | in_data.mask)
                                           : (modifiers & ~in_data.mask);
        end
        OP_KEY: begin
          // drop the key when the store is full
          if (!full) begin
            push        = 1'b1;
            wr_ptr_next = wr_step;
          end
        end
        OP_REL_X: pointer_x_next = rel_pos;
        OP_REL_Y: pointer_y_next = rel_pos;
        OP_ABS_X: pointer_x_next = in_data.coord;
        OP_ABS_Y: pointer_y_next = in_data.coord;
        default: begin
        end
      endcase
    end
    res.pointer_x     = 12'(pointer_x_next);
    res.pointer_y     = 12'(pointer_y_next);
    res.button_bits   = buttons_next;
    res.modifier_bits = modifiers_next;
    res.key_pending   = (wr_ptr_next != rd_ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x <= '0;
      pointer_y <= '0;
      buttons   <= '0;
      modifiers <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      pointer_x <= pointer_x_next;
      pointer_y <= pointer_y_next;
      buttons   <= buttons_next;
      modifiers <= modifiers_next;
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

  // key store with a registered head word; forward a write that lands on the head
  always_ff @(posedge clk) begin
    if (push) begin
      key_store[wr_ptr] <= entry;
    end
    if (push && wr_ptr == rd_ptr_next) begin
      head <= entry;
    end else begin
      head <= key_store[rd_ptr_next];
    end
  end

  assign out_data = result;

endmodule

// ----- rtl/input_event_translator_top.sv -----
// Input event translator. Each word on the input carries either an input event
// (type, code, value) or a request to pop one queued key; each word yields one
// result word with the pointer position, button and modifier masks, the popped
// key if any, and whether keys remain queued. One word is accepted per clock
// cycle, sustained, while the output is not stalled, and each result word is
// registered. The back end's state update sets the rate, one word per cycle
// unless stalled; the front end decodes keys and scales absolute positions
// over three pipeline stages (multiply, quotient estimate, correct and clamp)
// and feeds the back end through a four-word queue. Keys are held in a
// KEY_FIFO_DEPTH-entry store that holds KEY_FIFO_DEPTH-1 keys; a key arriving
// when it is full is dropped. No clearing pass after reset.
// Write the screen max registers only while the block is idle.
module input_event_translator_top #(
  parameter int KEY_FIFO_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  iet_pkg::event_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output iet_pkg::result_t                out_data,
  input  logic                            cfg_write,
  input  iet_pkg::cfg_reg_t               cfg_index,
  input  logic [iet_pkg::COORD_WIDTH-1:0] cfg_data
);
  import iet_pkg::*;

  logic [COORD_WIDTH-1:0] screen_max_x;
  logic [COORD_WIDTH-1:0] screen_max_y;

  logic  f_valid;
  logic  f_ready;
  work_t f_data;
  logic  q_valid;
  logic  q_ready;
  work_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_max_x <= RESET_MAX_X;
      screen_max_y <= RESET_MAX_Y;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_MAX_X: screen_max_x <= cfg_data;
        REG_SCREEN_MAX_Y: screen_max_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  iet_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .screen_max_x (screen_max_x),
    .screen_max_y (screen_max_y),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_data     (f_data)
  );

  iet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  iet_back #(
    .KEY_FIFO_DEPTH (KEY_FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_data      (q_data),
    .screen_max_x (screen_max_x),
    .screen_max_y (screen_max_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_no_key_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.key_valid |->
      out_data.key_code == 7'd0 && out_data.key_modifiers == 4'd0 && !out_data.key_pressed)
    else $error("key fields set without a popped key");

  a_front_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> f_valid && !f_ready)
    else $error("front stalled without a blocked word");

  a_back_stall_cause: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |-> out_valid && !out_ready)
    else $error("back end stalled while output register free");

endmodule

// ----- test/input_event_translator_top_tb.sv -----
module input_event_translator_top_tb;
  import iet_pkg::*;

  localparam int RING_DEPTH = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  localparam logic FUNC_EVENT = ~FUNC_POP;
  localparam logic [15:0] EV_SYN = 16'd0;

  localparam logic [15:0] KEY_A = 16'd30;
  localparam logic [15:0] KEY_UP = 16'd103;
  localparam logic [15:0] CODE_SHIFT_L = 16'd42;
  localparam logic [15:0] CODE_SHIFT_R = 16'd54;
  localparam logic [15:0] CODE_CTRL_L = 16'd29;
  localparam logic [15:0] CODE_CTRL_R = 16'd97;
  localparam logic [15:0] CODE_ALT_L = 16'd56;
  localparam logic [15:0] CODE_ALT_R = 16'd100;
  localparam logic [15:0] CODE_META_L = 16'd125;
  localparam logic [15:0] CODE_META_R = 16'd126;

  localparam logic [15:0] MODIFIER_KEYS [8] = '{CODE_SHIFT_L, CODE_SHIFT_R, CODE_CTRL_L,
                                               CODE_CTRL_R, CODE_ALT_L, CODE_ALT_R,
                                               CODE_META_L, CODE_META_R};

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  event_t in_data;
  logic out_valid;
  logic out_ready;
  result_t out_data;
  logic cfg_write;
  cfg_reg_t cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;

  input_event_translator_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // translator state as seen from outside
  logic [COORD_WIDTH-1:0] screen_x;
  logic [COORD_WIDTH-1:0] screen_y;
  logic [COORD_WIDTH-1:0] cursor_x;
  logic [COORD_WIDTH-1:0] cursor_y;
  logic [2:0] held_buttons;
  logic [3:0] held_mods;
  logic [11:0] key_ring [RING_DEPTH];
  int ring_wr;
  int ring_rd;

  event_t queued_events[$];
  result_t expected_reports[$];
  result_t want_report;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  // bit 7 flags a mapped code, low 7 bits hold the target keycode
  function automatic logic [7:0] keycode_of(input logic [15:0] code);
    logic [7:0] res;
    res = 8'h00;
    case (code)
      16'd1:   res = 8'h80 | 8'h35;
      16'd2:   res = 8'h80 | 8'h12;
      16'd3:   res = 8'h80 | 8'h13;
      16'd4:   res = 8'h80 | 8'h14;
      16'd5:   res = 8'h80 | 8'h15;
      16'd6:   res = 8'h80 | 8'h17;
      16'd7:   res = 8'h80 | 8'h16;
      16'd8:   res = 8'h80 | 8'h1A;
      16'd9:   res = 8'h80 | 8'h1C;
      16'd10:  res = 8'h80 | 8'h19;
      16'd11:  res = 8'h80 | 8'h1D;
      16'd12:  res = 8'h80 | 8'h1B;
      16'd13:  res = 8'h80 | 8'h18;
      16'd14:  res = 8'h80 | 8'h33;
      16'd15:  res = 8'h80 | 8'h30;
      16'd16:  res = 8'h80 | 8'h0C;
      16'd17:  res = 8'h80 | 8'h0D;
      16'd18:  res = 8'h80 | 8'h0E;
      16'd19:  res = 8'h80 | 8'h0F;
      16'd20:  res = 8'h80 | 8'h11;
      16'd21:  res = 8'h80 | 8'h10;
      16'd22:  res = 8'h80 | 8'h20;
      16'd23:  res = 8'h80 | 8'h22;
      16'd24:  res = 8'h80 | 8'h1F;
      16'd25:  res = 8'h80 | 8'h23;
      16'd26:  res = 8'h80 | 8'h21;
      16'd27:  res = 8'h80 | 8'h1E;
      16'd28:  res = 8'h80 | 8'h24;
      16'd30:  res = 8'h80 | 8'h00;
      16'd31:  res = 8'h80 | 8'h01;
      16'd32:  res = 8'h80 | 8'h02;
      16'd33:  res = 8'h80 | 8'h03;
      16'd34:  res = 8'h80 | 8'h05;
      16'd35:  res = 8'h80 | 8'h04;
      16'd36:  res = 8'h80 | 8'h26;
      16'd37:  res = 8'h80 | 8'h28;
      16'd38:  res = 8'h80 | 8'h25;
      16'd39:  res = 8'h80 | 8'h29;
      16'd40:  res = 8'h80 | 8'h27;
      16'd41:  res = 8'h80 | 8'h32;
      16'd43:  res = 8'h80 | 8'h2A;
      16'd44:  res = 8'h80 | 8'h06;
      16'd45:  res = 8'h80 | 8'h07;
      16'd46:  res = 8'h80 | 8'h08;
      16'd47:  res = 8'h80 | 8'h09;
      16'd48:  res = 8'h80 | 8'h0B;
      16'd49:  res = 8'h80 | 8'h2D;
      16'd50:  res = 8'h80 | 8'h2E;
      16'd51:  res = 8'h80 | 8'h2B;
      16'd52:  res = 8'h80 | 8'h2F;
      16'd53:  res = 8'h80 | 8'h2C;
      16'd57:  res = 8'h80 | 8'h31;
      16'd103: res = 8'h80 | 8'h7E;
      16'd105: res = 8'h80 | 8'h7B;
      16'd106: res = 8'h80 | 8'h7C;
      16'd108: res = 8'h80 | 8'h7D;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] modifier_of(input logic [15:0] code);
    if (code == CODE_SHIFT_L || code == CODE_SHIFT_R) return 4'b0001;
    if (code == CODE_CTRL_L || code == CODE_CTRL_R) return 4'b0010;
    if (code == CODE_ALT_L || code == CODE_ALT_R) return 4'b0100;
    if (code == CODE_META_L || code == CODE_META_R) return 4'b1000;
    return 4'b0000;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] move_by(input logic [COORD_WIDTH-1:0] pos,
                                                     input logic signed [31:0] delta,
                                                     input logic [COORD_WIDTH-1:0] lim);
    longint n;
    n = pos;
    n = n + delta;
    if (n < 0) n = 0;
    if (n > lim) n = lim;
    return n[COORD_WIDTH-1:0];
  endfunction

  // product wraps to 32 bits before the divide
  function automatic logic [COORD_WIDTH-1:0] scale_tablet(input logic [31:0] raw,
                                                          input logic [COORD_WIDTH-1:0] lim);
    logic [31:0] prod;
    logic [31:0] q;
    prod = raw * {{(32-COORD_WIDTH){1'b0}}, lim};
    q = prod / TABLET_FULL;
    if (q > {{(32-COORD_WIDTH){1'b0}}, lim}) q = {{(32-COORD_WIDTH){1'b0}}, lim};
    return q[COORD_WIDTH-1:0];
  endfunction

  function automatic result_t translate_event(input event_t ev);
    result_t r;
    logic pressed;
    logic [7:0] mapped;
    logic [3:0] mbit;
    logic [2:0] bbit;
    logic [11:0] entry;
    r = '0;
    pressed = (ev.event_value != 0);
    if (ev.func == FUNC_POP) begin
      if (ring_rd != ring_wr) begin
        entry = key_ring[ring_rd];
        r.key_valid = 1'b1;
        r.key_code = entry[6:0];
        r.key_modifiers = entry[10:7];
        r.key_pressed = entry[11];
        ring_rd = (ring_rd + 1) % RING_DEPTH;
      end
    end else if (ev.event_type == EV_KEY) begin
      mapped = keycode_of(ev.event_code);
      mbit = modifier_of(ev.event_code);
      if (ev.event_code >= BUTTON_BASE && ev.event_code <= BUTTON_LAST) begin
        bbit = 3'b001 << (ev.event_code - BUTTON_BASE);
        held_buttons = pressed ? (held_buttons | bbit) : (held_buttons & ~bbit);
      end else if (mbit != 4'b0000) begin
        held_mods = pressed ? (held_mods | mbit) : (held_mods & ~mbit);
      end else if (mapped[7] && (ring_wr + 1) % RING_DEPTH != ring_rd) begin
        key_ring[ring_wr] = {pressed, held_mods, mapped[6:0]};
        ring_wr = (ring_wr + 1) % RING_DEPTH;
      end
    end else if (ev.event_type == EV_REL) begin
      if (ev.event_code == AXIS_X) cursor_x = move_by(cursor_x, ev.event_value, screen_x);
      else if (ev.event_code == AXIS_Y) cursor_y = move_by(cursor_y, ev.event_value, screen_y);
    end else if (ev.event_type == EV_ABS) begin
      if (ev.event_code == AXIS_X) cursor_x = scale_tablet(ev.event_value, screen_x);
      else if (ev.event_code == AXIS_Y) cursor_y = scale_tablet(ev.event_value, screen_y);
    end
    r.pointer_x = cursor_x;
    r.pointer_y = cursor_y;
    r.button_bits = held_buttons;
    r.modifier_bits = held_mods;
    r.key_pending = (ring_rd != ring_wr);
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("x=%0d y=%0d btn=%b mod=%b kv=%b kc=%h km=%b kp=%b pend=%b",
                     r.pointer_x, r.pointer_y, r.button_bits, r.modifier_bits, r.key_valid,
                     r.key_code, r.key_modifiers, r.key_pressed, r.key_pending);
  endfunction

  // hold each word until taken; predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      cursor_x = '0;
      cursor_y = '0;
      held_buttons = '0;
      held_mods = '0;
      ring_wr = 0;
      ring_rd = 0;
    end else begin
      if (in_valid && in_ready) expected_reports.push_back(translate_event(in_data));
      if (!in_valid || in_ready) begin
        if (queued_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= queued_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) $display("unexpected result word: %s", show(out_data));
        end else begin
          want_report = expected_reports.pop_front();
          if (out_data.pointer_x !== want_report.pointer_x ||
              out_data.pointer_y !== want_report.pointer_y ||
              out_data.button_bits !== want_report.button_bits ||
              out_data.modifier_bits !== want_report.modifier_bits ||
              out_data.key_valid !== want_report.key_valid ||
              out_data.key_code !== want_report.key_code ||
              out_data.key_modifiers !== want_report.key_modifiers ||
              out_data.key_pressed !== want_report.key_pressed ||
              out_data.key_pending !== want_report.key_pending) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("result mismatch: expected %s", show(want_report));
              $display("                 actual   %s", show(out_data));
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_event(input logic func, input logic [15:0] kind,
                             input logic [15:0] code, input logic [31:0] value);
    event_t ev;
    ev.func = func;
    ev.event_type = kind;
    ev.event_code = code;
    ev.event_value = value;
    queued_events.push_back(ev);
  endtask

  function automatic event_t random_event(input int pop_pct);
    event_t ev;
    int roll;
    ev.func = FUNC_EVENT;
    ev.event_type = 16'($urandom);
    ev.event_code = 16'($urandom);
    ev.event_value = $urandom;
    if ($urandom_range(99) < pop_pct) begin
      ev.func = FUNC_POP;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        ev.event_type = EV_KEY;
        case ($urandom_range(5))
          0, 1, 2, 3: ev.event_code = 16'($urandom_range(127));
          4: ev.event_code = MODIFIER_KEYS[$urandom_range(7)];
          default: ev.event_code = 16'($urandom);
        endcase
        case ($urandom_range(3))
          0: ev.event_value = 0;
          1, 2: ev.event_value = 1;
          default: ev.event_value = $urandom;
        endcase
      end else if (roll < 50) begin
        ev.event_type = EV_KEY;
        ev.event_code = BUTTON_BASE + 16'($urandom_range(2));
        ev.event_value = $urandom_range(1);
      end else if (roll < 65) begin
        ev.event_type = EV_REL;
        ev.event_code = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1));
        case ($urandom_range(4))
          0, 1, 2: ev.event_value = $signed($urandom_range(200)) - 100;
          3: ev.event_value = $signed($urandom_range(10000)) - 5000;
          default: ev.event_value = $urandom;
        endcase
      end else if (roll < 80) begin
        ev.event_type = EV_ABS;
        ev.event_code = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1));
        case ($urandom_range(9))
          0: ev.event_value = TABLET_FULL;
          1, 2: ev.event_value = $urandom;
          default: ev.event_value = $urandom_range(32767);
        endcase
      end else if (roll < 88) begin
        ev.event_type = EV_SYN;
      end
      // otherwise leave type, code and value random as noise
    end
    return ev;
  endfunction

  // sample on the falling edge so every update of this cycle has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_events.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_screen(input logic [COORD_WIDTH-1:0] max_x,
                                input logic [COORD_WIDTH-1:0] max_y);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_MAX_X;
    cfg_data <= max_x;
    @(posedge clk);
    cfg_index <= REG_SCREEN_MAX_Y;
    cfg_data <= max_y;
    @(posedge clk);
    cfg_write <= 1'b0;
    screen_x = max_x;
    screen_y = max_y;
  endtask

  task automatic run_phase(input logic [COORD_WIDTH-1:0] max_x,
                           input logic [COORD_WIDTH-1:0] max_y,
                           input int send_pct, input int recv_pct, input int pop_pct,
                           input int count);
    wait_idle();
    program_screen(max_x, max_y);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) queued_events.push_back(random_event(pop_pct));
    wait_idle();
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SCREEN_MAX_X;
    cfg_data = '0;
    screen_x = RESET_MAX_X;
    screen_y = RESET_MAX_Y;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: clamps, wrap of the tablet product, ignored events, masks, queue
    queue_event(FUNC_POP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_event(FUNC_EVENT, EV_REL, AXIS_X, 32'd100000);
    queue_event(FUNC_EVENT, EV_REL, AXIS_X, 32'h8000_0000);
    queue_event(FUNC_EVENT, EV_REL, AXIS_Y, 32'h7FFF_FFFF);
    queue_event(FUNC_EVENT, EV_ABS, AXIS_X, TABLET_FULL);
    queue_event(FUNC_EVENT, EV_ABS, AXIS_X, 32'hFFFF_FFFF);
    queue_event(FUNC_EVENT, EV_ABS, AXIS_Y, 32'd16384);
    queue_event(FUNC_EVENT, EV_REL, 16'd2, 32'd5);
    queue_event(FUNC_EVENT, EV_ABS, 16'hFFFF, 32'd100);
    queue_event(FUNC_EVENT, 16'hFFFF, AXIS_Y, 32'd1);
    queue_event(FUNC_EVENT, EV_SYN, 16'd0, 32'd0);
    queue_event(FUNC_EVENT, EV_KEY, BUTTON_BASE, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, BUTTON_BASE + 16'd1, 32'h8000_0000);
    queue_event(FUNC_EVENT, EV_KEY, BUTTON_LAST, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, BUTTON_BASE + 16'd1, 32'd0);
    queue_event(FUNC_EVENT, EV_KEY, CODE_SHIFT_L, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, CODE_META_R, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, KEY_A, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, 16'd0, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, 16'h0200, 32'd1);
    queue_event(FUNC_EVENT, EV_KEY, CODE_META_L, 32'd0);
    queue_event(FUNC_EVENT, EV_KEY, KEY_UP, 32'd0);
    queue_event(FUNC_POP, 16'd0, 16'd0, 32'd0);
    queue_event(FUNC_POP, 16'd0, 16'd0, 32'd0);
    queue_event(FUNC_POP, 16'd0, 16'd0, 32'd0);
    wait_idle();

    run_phase(12'd4095, 12'd4095, 58, 0, 15, 250);
    run_phase(12'd1, 12'd1, 0, 58, 40, 250);
    run_phase(12'd0, 12'd4095, 27, 27, 5, 250);
    run_phase(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 0, 0, 20, 250);
    run_phase(12'd4095, 12'd0, 58, 0, 30, 200);
    run_phase(RESET_MAX_X, RESET_MAX_Y, 27, 27, 15, 200);
    run_phase(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 0, 58, 10, 150);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/iet_pkg.sv
rtl/iet_front.sv
rtl/iet_queue.sv
rtl/iet_back.sv
rtl/input_event_translator_top.sv
test/input_event_translator_top_tb.sv
